[rtl/pcpr_pkg.sv]
// ----------------------------------------------------------------------------
// pcpr_pkg
// Shared types and constants for the pure color palette recolor block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcpr_pkg;

    // palettes in R, G, Y, B, M, C, W order
    localparam int NUM_PALETTES = 7;
    localparam int NUM_CH       = 3;
    localparam int CH_W         = 8;
    localparam int LEN_W        = 5;
    localparam int SEL_W        = 3;
    localparam int IDX_W        = 4;
    localparam int FULL_SCALE   = 255;

    // apb register window
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // channel slots inside a packed color, red on top
    localparam int CH_RED   = 2;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 0;

    typedef logic [NUM_CH-1:0][CH_W-1:0] t_rgb;

    typedef enum logic {
        MODE_RECOLOR = 1'b0,
        MODE_WRITE   = 1'b1
    } t_mode;

    // truncating x / 255 as (x + 1) * 257 >> 16, exact for x below 65280
    function automatic logic [CH_W-1:0] div_by_255(input logic [2*CH_W-1:0] x);
        logic [3*CH_W:0] y;
        y = (3*CH_W+1)'(x) + 1'b1;
        y = y + (y << CH_W);
        return y[3*CH_W-1:2*CH_W];
    endfunction

endpackage

[rtl/pure_color_palette_recolor.sv]
// ----------------------------------------------------------------------------
// pure_color_palette_recolor
// Seven stages (s1 to s7) separate an input transfer from its result.
// Throughput: one item per clock while the output is not stalled; the palette
// memory has one write and two read ports, so reads and writes never compete.
// A stalled output freezes all stages; the input stalls only then.
// Synchronous reset clears the stage valid bits and the length registers;
// palette memory is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pure_color_palette_recolor
    import pcpr_pkg::*;
#(
    parameter int PALETTE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,

    // input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_mode,
    input  logic [SEL_W-1:0]   i_palette_select,
    input  logic [IDX_W-1:0]   i_entry_index,
    input  logic [CH_W-1:0]    i_pixel_red,
    input  logic [CH_W-1:0]    i_pixel_green,
    input  logic [CH_W-1:0]    i_pixel_blue,

    // output channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [CH_W-1:0]    o_out_red,
    output logic [CH_W-1:0]    o_out_green,
    output logic [CH_W-1:0]    o_out_blue,
    output logic               o_was_dyed
);

    localparam int MEM_DEPTH = NUM_PALETTES * PALETTE_DEPTH;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int SEG_W     = LEN_W;
    localparam int P_W       = CH_W + LEN_W;
    localparam int SUM_W     = 2 * CH_W;
    localparam int RIDX_W    = PADDR_W - 2;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [LEN_W-1:0]  r_pal_len [NUM_PALETTES];
    logic [RIDX_W-1:0] w_reg_idx;
    logic              w_reg_hit;
    logic              w_cfg_wr;

    assign w_reg_idx = paddr[PADDR_W-1:2];
    assign w_reg_hit = (32'(w_reg_idx) < NUM_PALETTES);
    assign w_cfg_wr  = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = w_reg_hit ? PDATA_W'(r_pal_len[w_reg_idx]) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_PALETTES; k++) begin
                r_pal_len[k] <= '0;
            end
        end else if (w_cfg_wr && w_reg_hit) begin
            r_pal_len[w_reg_idx] <= pwdata[LEN_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // pipeline enable and handshake
    // ------------------------------------------------------------------
    logic w_adv;
    logic w_accept;

    logic r_s1_res, r_s2_res, r_s3_res, r_s4_res, r_s5_res, r_s6_res, r_s7_res;
    logic r_s1_wr, r_s2_wr, r_s3_wr;

    assign w_adv    = !(r_s7_res && i_stall);
    assign o_stall  = !w_adv;
    assign w_accept = i_valid && w_adv;
    assign o_valid  = r_s7_res;

    // ------------------------------------------------------------------
    // stage 1: classify pixel, pick palette and length
    // ------------------------------------------------------------------
    t_rgb             w_col;
    logic [CH_W-1:0]  w_max, w_min;
    logic [CH_W+1:0]  w_sum;
    logic             w_pure;
    logic [SEL_W-1:0] w_pal;
    logic [LEN_W-1:0] w_len_raw, w_len;
    logic             n_dye;
    logic             n_wr_en;
    logic [AW-1:0]    n_base, n_wr_addr;

    always_comb begin
        w_col[CH_RED]   = i_pixel_red;
        w_col[CH_GREEN] = i_pixel_green;
        w_col[CH_BLUE]  = i_pixel_blue;

        w_max = i_pixel_red;
        if (i_pixel_green > w_max) w_max = i_pixel_green;
        if (i_pixel_blue > w_max)  w_max = i_pixel_blue;
        w_min = i_pixel_red;
        if (i_pixel_green < w_min) w_min = i_pixel_green;
        if (i_pixel_blue < w_min)  w_min = i_pixel_blue;
        w_sum = (CH_W+2)'(i_pixel_red) + (CH_W+2)'(i_pixel_green)
              + (CH_W+2)'(i_pixel_blue);

        // gray, or all nonzero channels equal
        w_pure = (w_min == w_max) ||
                 ((w_min == '0) && ((w_sum == (CH_W+2)'(w_max)) ||
                                    (w_sum == ((CH_W+2)'(w_max) << 1))));

        w_pal = {i_pixel_blue != '0, i_pixel_green != '0, i_pixel_red != '0}
              - SEL_W'(1);
        w_len_raw = (32'(w_pal) < NUM_PALETTES) ? r_pal_len[w_pal] : '0;
        w_len = (32'(w_len_raw) > PALETTE_DEPTH) ? LEN_W'(PALETTE_DEPTH) : w_len_raw;

        n_dye  = (w_max != '0) && w_pure && (w_len != '0);
        n_base = AW'(32'(w_pal) * PALETTE_DEPTH);

        n_wr_en   = (i_mode == MODE_WRITE) &&
                    (32'(i_palette_select) < NUM_PALETTES) &&
                    (32'(i_entry_index) < PALETTE_DEPTH);
        n_wr_addr = AW'(32'(i_palette_select) * PALETTE_DEPTH + 32'(i_entry_index));
    end

    // ------------------------------------------------------------------
    // stage 3 logic: segment and fraction, p / 255 and p % 255
    // ------------------------------------------------------------------
    logic [P_W-1:0]   r_s2_p;
    logic [CH_W-1:0]  w_q8;
    logic [SEG_W-1:0] w_seg;
    logic [P_W:0]     w_tx;
    logic [CH_W-1:0]  w_t;
    logic [SEG_W-1:0] n_hi_seg, n_lo_seg;
    logic             n_lo_black;

    always_comb begin
        w_q8  = div_by_255(SUM_W'(r_s2_p));
        w_seg = w_q8[SEG_W-1:0];
        w_tx  = (P_W+1)'(r_s2_p) - ((P_W+1)'(w_seg) << CH_W) + (P_W+1)'(w_seg);
        w_t   = w_tx[CH_W-1:0];
        // exact hit reads entry seg-1 on both sides
        n_lo_seg   = w_seg - SEG_W'(1);
        n_hi_seg   = (w_t == '0) ? n_lo_seg : w_seg;
        n_lo_black = (w_seg == '0);
    end

    // ------------------------------------------------------------------
    // stage 4: palette memory, write and read in the same stage
    // ------------------------------------------------------------------
    t_rgb             r_mem [MEM_DEPTH];
    logic [AW-1:0]    r_s3_base, r_s3_wr_addr;
    logic [SEG_W-1:0] r_s3_hi_seg, r_s3_lo_seg;
    t_rgb             r_s3_col;
    logic [AW-1:0]    w_hi_addr, w_lo_addr;
    t_rgb             r_s4_hi, r_s4_lo;

    assign w_hi_addr = r_s3_base + AW'(r_s3_hi_seg);
    assign w_lo_addr = r_s3_base + AW'(r_s3_lo_seg);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r_s3_wr) begin
                r_mem[r_s3_wr_addr] <= r_s3_col;
            end
            r_s4_hi <= r_mem[w_hi_addr];
            r_s4_lo <= r_mem[w_lo_addr];
        end
    end

    // ------------------------------------------------------------------
    // stage 5 logic: weights, black below the first entry
    // ------------------------------------------------------------------
    logic [CH_W-1:0] r_s4_t;
    logic            r_s4_lo_black;
    t_rgb            w_lo;
    logic [CH_W-1:0] w_lo_w;

    assign w_lo   = r_s4_lo_black ? '0 : r_s4_lo;
    assign w_lo_w = CH_W'(FULL_SCALE) - r_s4_t;

    // ------------------------------------------------------------------
    // valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_res <= 1'b0;
            r_s2_res <= 1'b0;
            r_s3_res <= 1'b0;
            r_s4_res <= 1'b0;
            r_s5_res <= 1'b0;
            r_s6_res <= 1'b0;
            r_s7_res <= 1'b0;
            r_s1_wr  <= 1'b0;
            r_s2_wr  <= 1'b0;
            r_s3_wr  <= 1'b0;
        end else if (w_adv) begin
            r_s1_res <= w_accept && (i_mode == MODE_RECOLOR);
            r_s1_wr  <= w_accept && n_wr_en;
            r_s2_res <= r_s1_res;
            r_s2_wr  <= r_s1_wr;
            r_s3_res <= r_s2_res;
            r_s3_wr  <= r_s2_wr;
            r_s4_res <= r_s3_res;
            r_s5_res <= r_s4_res;
            r_s6_res <= r_s5_res;
            r_s7_res <= r_s6_res;
        end
    end

    // ------------------------------------------------------------------
    // payload stages
    // ------------------------------------------------------------------
    t_rgb             r_s1_col, r_s2_col, r_s4_col, r_s5_col, r_s6_col, r_s7_col;
    logic             r_s1_dye, r_s2_dye, r_s3_dye, r_s4_dye, r_s5_dye, r_s6_dye;
    logic             r_s7_dye;
    logic [AW-1:0]    r_s1_base, r_s2_base, r_s1_wr_addr, r_s2_wr_addr;
    logic [CH_W-1:0]  r_s1_max;
    logic [LEN_W-1:0] r_s1_len;
    logic [CH_W-1:0]  r_s3_t;
    logic             r_s3_lo_black;
    logic [SUM_W-1:0] r_s5_lo_prod [NUM_CH];
    logic [SUM_W-1:0] r_s5_hi_prod [NUM_CH];
    logic [SUM_W-1:0] r_s6_sum     [NUM_CH];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // stage 1
            r_s1_col     <= w_col;
            r_s1_dye     <= n_dye;
            r_s1_base    <= n_base;
            r_s1_wr_addr <= n_wr_addr;
            r_s1_max     <= w_max;
            r_s1_len     <= w_len;

            // stage 2: intensity times length
            r_s2_col     <= r_s1_col;
            r_s2_dye     <= r_s1_dye;
            r_s2_base    <= r_s1_base;
            r_s2_wr_addr <= r_s1_wr_addr;
            r_s2_p       <= P_W'(r_s1_max) * P_W'(r_s1_len);

            // stage 3: segment indexes and fraction
            r_s3_col      <= r_s2_col;
            r_s3_dye      <= r_s2_dye;
            r_s3_base     <= r_s2_base;
            r_s3_wr_addr  <= r_s2_wr_addr;
            r_s3_t        <= w_t;
            r_s3_hi_seg   <= n_hi_seg;
            r_s3_lo_seg   <= n_lo_seg;
            r_s3_lo_black <= n_lo_black;

            // stage 4: memory read data lands alongside
            r_s4_col      <= r_s3_col;
            r_s4_dye      <= r_s3_dye;
            r_s4_t        <= r_s3_t;
            r_s4_lo_black <= r_s3_lo_black;

            // stage 5: weighted products
            r_s5_col <= r_s4_col;
            r_s5_dye <= r_s4_dye;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_s5_lo_prod[ch] <= SUM_W'(w_lo_w) * SUM_W'(w_lo[ch]);
                r_s5_hi_prod[ch] <= SUM_W'(r_s4_t) * SUM_W'(r_s4_hi[ch]);
            end

            // stage 6: blend sums
            r_s6_col <= r_s5_col;
            r_s6_dye <= r_s5_dye;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_s6_sum[ch] <= r_s5_lo_prod[ch] + r_s5_hi_prod[ch];
            end

            // stage 7: divide by full scale, pass-through otherwise
            r_s7_dye <= r_s6_dye;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_s7_col[ch] <= r_s6_dye ? div_by_255(r_s6_sum[ch]) : r_s6_col[ch];
            end
        end
    end

    assign o_out_red   = r_s7_col[CH_RED];
    assign o_out_green = r_s7_col[CH_GREEN];
    assign o_out_blue  = r_s7_col[CH_BLUE];
    assign o_was_dyed  = r_s7_dye;

endmodule

[rtl/pcpr_checker.sv]
// ----------------------------------------------------------------------------
// pcpr_checker
// Port-level checks for the pure color palette recolor block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcpr_checker
    import pcpr_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [PADDR_W-1:0] paddr,
    input logic [PDATA_W-1:0] pwdata,
    input logic [PDATA_W-1:0] prdata,
    input logic               pready,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic [CH_W-1:0]    o_out_red,
    input logic [CH_W-1:0]    o_out_green,
    input logic [CH_W-1:0]    o_out_blue,
    input logic               o_was_dyed
);

    // input stalls exactly when a finished result is held back
    a_stall_link: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall)
    ) else $error("input stall does not match a held result");

    // a held result keeps its payload
    a_out_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_red) &&
            $stable(o_out_green) && $stable(o_out_blue) && $stable(o_was_dyed))
    ) else $error("stalled result changed");

    // nothing comes out right after reset
    a_reset_empty: assert property (
        @(posedge i_clk)
        !i_rst_n |=> !o_valid
    ) else $error("result present after reset");

    // a length register reads back what was written to it
    a_cfg_readback: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(psel && penable && pwrite && pready) &&
         (paddr == $past(paddr)) && (32'(paddr[PADDR_W-1:2]) < NUM_PALETTES))
        |-> (prdata == PDATA_W'($past(pwdata[LEN_W-1:0])))
    ) else $error("length register readback mismatch");

endmodule

bind pure_color_palette_recolor pcpr_checker u_pcpr_checker (.*);

[tb/pure_color_palette_recolor_test.sv]
// ----------------------------------------------------------------------------
// pure_color_palette_recolor_test
// Self-checking bench for the palette recolor block. Loads every palette
// entry, runs directed pixels over black, impure, pure and saturated cases,
// then random traffic over many palette length settings. A shadow model
// predicts each recolored pixel and a monitor compares every output transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pure_color_palette_recolor_test;
    import pcpr_pkg::*;

    localparam int PALETTE_DEPTH = 16;
    localparam int DRAIN_CYCLES  = 12;
    localparam int TIMEOUT_NS    = 1_000_000;

    // palette order doubles as the length register index
    typedef enum logic [SEL_W-1:0] {
        PAL_RED,
        PAL_GREEN,
        PAL_YELLOW,
        PAL_BLUE,
        PAL_MAGENTA,
        PAL_CYAN,
        PAL_WHITE,
        PAL_NONE
    } t_palette;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            dyed;
    } t_pixel_result;

    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               psel             = 1'b0;
    logic               penable          = 1'b0;
    logic               pwrite           = 1'b0;
    logic [PADDR_W-1:0] paddr            = '0;
    logic [PDATA_W-1:0] pwdata           = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               i_valid          = 1'b0;
    logic               o_stall;
    logic               i_mode           = 1'b0;
    logic [SEL_W-1:0]   i_palette_select = '0;
    logic [IDX_W-1:0]   i_entry_index    = '0;
    logic [CH_W-1:0]    i_pixel_red      = '0;
    logic [CH_W-1:0]    i_pixel_green    = '0;
    logic [CH_W-1:0]    i_pixel_blue     = '0;
    logic               o_valid;
    logic               i_stall          = 1'b0;
    logic [CH_W-1:0]    o_out_red;
    logic [CH_W-1:0]    o_out_green;
    logic [CH_W-1:0]    o_out_blue;
    logic               o_was_dyed;

    // shadow state of the block
    t_rgb              palette_shadow [NUM_PALETTES][PALETTE_DEPTH];
    logic [LEN_W-1:0]  length_shadow [NUM_PALETTES];
    t_pixel_result     expected_pixels [$];

    int unsigned error_count  = 0;
    int unsigned stall_left   = 0;
    bit          gaps_enabled = 1'b1;

    pure_color_palette_recolor u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_mode           (i_mode),
        .i_palette_select (i_palette_select),
        .i_entry_index    (i_entry_index),
        .i_pixel_red      (i_pixel_red),
        .i_pixel_green    (i_pixel_green),
        .i_pixel_blue     (i_pixel_blue),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_red        (o_out_red),
        .o_out_green      (o_out_green),
        .o_out_blue       (o_out_blue),
        .o_was_dyed       (o_was_dyed)
    );

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // mismatch reporting
    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    // idle length: mostly none or short, a few long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (!gaps_enabled) return 0;
        roll = $urandom_range(99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    // expected recolor of one pixel from the shadow palettes
    function automatic t_pixel_result predict_recolor(input t_rgb color);
        t_pixel_result res;
        int unsigned   cmax, cmin, sum, len, pal, p, seg, t, k;
        t_rgb          lo, hi, mixed;
        res.red   = color[CH_RED];
        res.green = color[CH_GREEN];
        res.blue  = color[CH_BLUE];
        res.dyed  = 1'b0;
        cmax = color[CH_RED];
        cmin = color[CH_RED];
        for (k = 0; k < NUM_CH; k++) begin
            if (color[k] > cmax) cmax = color[k];
            if (color[k] < cmin) cmin = color[k];
        end
        if (cmax == 0) return res;
        sum = color[CH_RED] + color[CH_GREEN] + color[CH_BLUE];
        // impure: nonzero channels differ
        if (cmin != cmax && (cmin != 0 || (sum != cmax && sum != 2 * cmax))) return res;
        pal = (color[CH_RED] != 0 ? 1 : 0) | (color[CH_GREEN] != 0 ? 2 : 0) |
              (color[CH_BLUE] != 0 ? 4 : 0);
        pal = pal - 1;
        len = length_shadow[pal];
        if (len > PALETTE_DEPTH) len = PALETTE_DEPTH;
        if (len == 0) return res;
        p   = cmax * len;
        seg = p / FULL_SCALE;
        t   = p % FULL_SCALE;
        if (t == 0) begin
            // exact hit on an entry
            mixed = palette_shadow[pal][seg - 1];
        end else begin
            // blend between neighbors, implicit black below entry zero
            hi = palette_shadow[pal][seg];
            lo = (seg > 0) ? palette_shadow[pal][seg - 1] : '0;
            for (k = 0; k < NUM_CH; k++) begin
                mixed[k] = CH_W'(((FULL_SCALE - t) * lo[k] + t * hi[k]) / FULL_SCALE);
            end
        end
        res.red   = mixed[CH_RED];
        res.green = mixed[CH_GREEN];
        res.blue  = mixed[CH_BLUE];
        res.dyed  = 1'b1;
        return res;
    endfunction

    function automatic t_rgb make_pure(input int unsigned mask, input int unsigned level);
        t_rgb c;
        c[CH_RED]   = mask[0] ? CH_W'(level) : '0;
        c[CH_GREEN] = mask[1] ? CH_W'(level) : '0;
        c[CH_BLUE]  = mask[2] ? CH_W'(level) : '0;
        return c;
    endfunction

    // intensity biased toward extremes and exact palette hits
    function automatic int unsigned pick_intensity(input int unsigned len);
        int unsigned eff, step, roll;
        eff  = (len > PALETTE_DEPTH) ? PALETTE_DEPTH : len;
        roll = $urandom_range(9);
        if (roll == 0) return 255;
        if (roll == 1) return 1;
        if (roll <= 3 && eff != 0) begin
            step = 1;
            while ((step * eff) % FULL_SCALE != 0) step++;
            return step * $urandom_range(255 / step, 1);
        end
        return $urandom_range(255, 1);
    endfunction

    function automatic logic [NUM_PALETTES-1:0][LEN_W-1:0] random_lengths();
        logic [NUM_PALETTES-1:0][LEN_W-1:0] lens;
        int unsigned roll;
        int          p;
        for (p = 0; p < NUM_PALETTES; p++) begin
            roll = $urandom_range(99);
            if (roll < 15)      lens[p] = '0;
            else if (roll < 25) lens[p] = LEN_W'($urandom_range(31, 17));
            else                lens[p] = LEN_W'($urandom_range(16, 1));
        end
        return lens;
    endfunction

    // one input transfer, shadow updated at acceptance
    task automatic send_item(input t_mode mode, input logic [SEL_W-1:0] sel,
                             input logic [IDX_W-1:0] idx, input t_rgb color);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_mode           <= mode;
        i_palette_select <= sel;
        i_entry_index    <= idx;
        i_pixel_red      <= color[CH_RED];
        i_pixel_green    <= color[CH_GREEN];
        i_pixel_blue     <= color[CH_BLUE];
        do @(posedge i_clk); while (o_stall !== 1'b0);
        if (mode == MODE_WRITE) begin
            if (sel != PAL_NONE) palette_shadow[sel][idx] = color;
        end else begin
            expected_pixels = {expected_pixels, predict_recolor(color)};
        end
    endtask

    // wait for all results plus the pipeline tail
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // apb transfers leave psel high, the caller releases the bus
    task automatic apb_write(input int unsigned reg_idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(reg_idx * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (reg_idx < NUM_PALETTES) length_shadow[reg_idx] = value[LEN_W-1:0];
    endtask

    task automatic apb_read(input int unsigned reg_idx, output logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= PADDR_W'(reg_idx * 4);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        data = prdata;
    endtask

    // read back every length register, then release the bus
    task automatic check_lengths();
        logic [PDATA_W-1:0] data;
        int unsigned        p;
        for (p = 0; p < NUM_PALETTES; p++) begin
            apb_read(p, data);
            if (data !== PDATA_W'(length_shadow[p])) begin
                flag_error($sformatf("length reg %0d read %0h want %0h",
                                     p, data, length_shadow[p]));
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_lengths(input logic [NUM_PALETTES-1:0][LEN_W-1:0] lens);
        int unsigned p;
        wait_idle();
        for (p = 0; p < NUM_PALETTES; p++) apb_write(p, PDATA_W'(lens[p]));
        // address past the last register must not disturb anything
        apb_write(PAL_NONE, PDATA_W'($urandom_range(31, 1)));
        check_lengths();
    endtask

    // random traffic: mostly pure pixels, some palette writes and noise
    task automatic random_burst(input int unsigned count);
        int unsigned roll, mask;
        t_rgb        color;
        repeat (count) begin
            roll  = $urandom_range(99);
            color = t_rgb'($urandom);
            mask  = $urandom_range(7, 1);
            if (roll < 12) begin
                send_item(MODE_WRITE, SEL_W'($urandom_range(7)), IDX_W'($urandom), color);
            end else if (roll < 18) begin
                send_item(MODE_RECOLOR, SEL_W'($urandom), IDX_W'($urandom), '0);
            end else if (roll < 30) begin
                send_item(MODE_RECOLOR, SEL_W'($urandom), IDX_W'($urandom), color);
            end else begin
                send_item(MODE_RECOLOR, SEL_W'($urandom), IDX_W'($urandom),
                          make_pure(mask, pick_intensity(length_shadow[mask - 1])));
            end
        end
    endtask

    // lengths come up zero, so every pixel passes undyed
    task automatic test_reset_state();
        check_lengths();
        random_burst(16);
    endtask

    // write every entry of every palette
    task automatic test_palette_load();
        int unsigned pal, idx, roll;
        t_rgb        color;
        for (pal = 0; pal < NUM_PALETTES; pal++) begin
            for (idx = 0; idx < PALETTE_DEPTH; idx++) begin
                roll = $urandom_range(9);
                if (roll == 0)      color = '1;
                else if (roll == 1) color = '0;
                else                color = t_rgb'($urandom);
                send_item(MODE_WRITE, SEL_W'(pal), IDX_W'(idx), color);
            end
        end
        send_item(MODE_WRITE, PAL_NONE, IDX_W'($urandom), t_rgb'($urandom));
    endtask

    task automatic test_directed_cases();
        logic [NUM_PALETTES-1:0][LEN_W-1:0] lens;
        lens[PAL_RED]     = 5'd16;
        lens[PAL_GREEN]   = 5'd1;
        lens[PAL_YELLOW]  = 5'd15;
        lens[PAL_BLUE]    = 5'd5;
        lens[PAL_MAGENTA] = 5'd3;
        lens[PAL_CYAN]    = 5'd31;
        lens[PAL_WHITE]   = 5'd0;
        program_lengths(lens);
        // black and gray with a disabled palette
        send_item(MODE_RECOLOR, PAL_RED, 4'd0, {8'd0, 8'd0, 8'd0});
        send_item(MODE_RECOLOR, PAL_RED, 4'd0, {8'd255, 8'd255, 8'd255});
        // write then read the same entry right away
        send_item(MODE_WRITE, PAL_RED, 4'd15, 24'h123456);
        send_item(MODE_RECOLOR, PAL_RED, 4'd0, {8'd255, 8'd0, 8'd0});
        send_item(MODE_RECOLOR, PAL_RED, 4'd0, {8'd1, 8'd0, 8'd0});
        send_item(MODE_WRITE, PAL_GREEN, 4'd0, 24'hFFFFFF);
        send_item(MODE_RECOLOR, PAL_RED, 4'd0, {8'd0, 8'd255, 8'd0});
        send_item(MODE_RECOLOR, PAL_RED, 4'd0, {8'd0, 8'd128, 8'd0});
        // exact hits, and one blend, on two-channel and blue palettes
        send_item(MODE_RECOLOR, PAL_RED, 4'd0, {8'd17, 8'd17, 8'd0});
        send_item(MODE_RECOLOR, PAL_RED, 4'd0, {8'd200, 8'd200, 8'd0});
        send_item(MODE_RECOLOR, PAL_RED, 4'd0, {8'd0, 8'd0, 8'd51});
        send_item(MODE_RECOLOR, PAL_RED, 4'd0, {8'd85, 8'd0, 8'd85});
        send_item(MODE_RECOLOR, PAL_RED, 4'd0, {8'd170, 8'd0, 8'd170});
        // length above depth saturates
        send_item(MODE_RECOLOR, PAL_RED, 4'd0, {8'd0, 8'd200, 8'd200});
        send_item(MODE_RECOLOR, PAL_RED, 4'd0, {8'd0, 8'd1, 8'd1});
        // impure pixels pass through
        send_item(MODE_RECOLOR, PAL_RED, 4'd0, {8'd10, 8'd20, 8'd30});
        send_item(MODE_RECOLOR, PAL_RED, 4'd0, {8'd10, 8'd20, 8'd0});
        send_item(MODE_RECOLOR, PAL_RED, 4'd0, {8'd5, 8'd5, 8'd6});
        // write to the missing palette is dropped
        send_item(MODE_WRITE, PAL_NONE, 4'd15, 24'hABCDEF);
        send_item(MODE_RECOLOR, PAL_RED, 4'd0, {8'd255, 8'd0, 8'd0});
        send_item(MODE_RECOLOR, PAL_NONE, 4'd15, {8'd128, 8'd128, 8'd128});
    endtask

    task automatic test_length_extremes();
        logic [NUM_PALETTES-1:0][LEN_W-1:0] lens;
        int unsigned p;
        lens = {NUM_PALETTES{5'd1}};
        program_lengths(lens);
        random_burst(80);
        lens = {NUM_PALETTES{5'd16}};
        program_lengths(lens);
        random_burst(80);
        lens = {NUM_PALETTES{5'd31}};
        program_lengths(lens);
        random_burst(80);
        for (p = 0; p < NUM_PALETTES; p++) lens[p] = p[0] ? 5'd0 : 5'd16;
        program_lengths(lens);
        random_burst(80);
    endtask

    task automatic test_random_lengths();
        repeat (5) begin
            program_lengths(random_lengths());
            random_burst(150);
        end
    endtask

    // back-to-back transfers with no idling on either side
    task automatic test_streaming();
        program_lengths(random_lengths());
        gaps_enabled = 1'b0;
        random_burst(200);
        gaps_enabled = 1'b1;
    endtask

    // result monitor and random output stall
    task automatic compare_field(input string name, input logic [CH_W-1:0] got,
                                 input logic [CH_W-1:0] want);
        if (got !== want) begin
            flag_error($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    task automatic check_result();
        t_pixel_result want;
        if (expected_pixels.size() == 0) begin
            flag_error("result transfer with nothing expected");
            return;
        end
        want = expected_pixels.pop_front();
        compare_field("red", o_out_red, want.red);
        compare_field("green", o_out_green, want.green);
        compare_field("blue", o_out_blue, want.blue);
        compare_field("was_dyed", CH_W'(o_was_dyed), CH_W'(want.dyed));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid === 1'b1 && i_stall == 1'b0) check_result();
            if (stall_left != 0) stall_left = stall_left - 1;
            else                 stall_left = pick_gap();
            i_stall <= (stall_left != 0);
        end
    end

    // test sequence
    initial begin
        foreach (length_shadow[p]) length_shadow[p] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_palette_load();
        test_directed_cases();
        test_length_extremes();
        test_random_lengths();
        test_streaming();
        wait_idle();
        if (error_count == 0) begin
            $display("pure_color_palette_recolor_test passed");
        end else begin
            $display("pure_color_palette_recolor_test failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("pure_color_palette_recolor_test failed");
        $finish;
    end

endmodule
